[hdl/nsct_pkg.sv]
// Package for the nested script count tracker.
// Holds the word types, command codes and controller types; every module imports it.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package nsct_pkg;

    // Operation codes carried in a request word.
    localparam logic [7:0] OP_COMPLEX = 8'h01;
    localparam logic [7:0] OP_SIMPLE  = 8'h02;
    localparam logic [7:0] OP_FINISH  = 8'h03;

    // Script type codes.
    localparam logic [7:0] TYPE_PUBKEY    = 8'd0;
    localparam logic [7:0] TYPE_ALL       = 8'd1;
    localparam logic [7:0] TYPE_ANY       = 8'd2;
    localparam logic [7:0] TYPE_NOFK      = 8'd3;
    localparam logic [7:0] TYPE_BEFORE    = 8'd4;
    localparam logic [7:0] TYPE_HEREAFTER = 8'd5;

    // Pubkey reference kinds.
    localparam logic [7:0] KEYREF_PATH = 8'd1;
    localparam logic [7:0] KEYREF_HASH = 8'd2;

    // Finish formats.
    localparam logic [7:0] FMT_BECH32    = 8'd1;
    localparam logic [7:0] FMT_POLICY_ID = 8'd2;

    // Result status codes.
    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_STATE   = 2'd1;
    localparam logic [1:0] ST_DATA    = 2'd2;
    localparam logic [1:0] ST_REQUEST = 2'd3;

    // Hash builder actions.
    localparam logic [2:0] HC_NONE      = 3'd0;
    localparam logic [2:0] HC_ALL       = 3'd1;
    localparam logic [2:0] HC_ANY       = 3'd2;
    localparam logic [2:0] HC_NOFK      = 3'd3;
    localparam logic [2:0] HC_PUBKEY    = 3'd4;
    localparam logic [2:0] HC_BEFORE    = 3'd5;
    localparam logic [2:0] HC_HEREAFTER = 3'd6;
    localparam logic [2:0] HC_FINALIZE  = 3'd7;

    // Request word.
    typedef struct packed {
        logic [7:0]  operation;
        logic        new_call;
        logic [7:0]  script_type;
        logic [7:0]  key_reference;
        logic [31:0] nested_count;
        logic [31:0] required_count;
        logic [7:0]  finish_format;
    } req_t;

    // Response word.
    typedef struct packed {
        logic [1:0]  status;
        logic [2:0]  hash_command;
        logic [2:0]  depth;
        logic [31:0] remaining_here;
    } rsp_t;

    // Controller states.
    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_POP_CHECK,
        S_POP_LOAD,
        S_DONE
    } ctl_state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load_in;
        logic exec;
        logic pop_rd;
        logic pop_ld;
        logic load_out;
    } ctl_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic pop_needed;
        logic out_free;
    } dp_stat_t;

endpackage

`default_nettype wire

[hdl/nsct_datapath.sv]
// Datapath of the nested script count tracker: request register, level and
// top-of-stack registers, the stack memory of parent counts and the response register.
// Depends on nsct_pkg.
`timescale 1ns / 1ps
`default_nettype none

module nsct_datapath #(
    parameter int MAX_DEPTH = 8
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire nsct_pkg::req_t      req,
    input  wire nsct_pkg::ctl_cmd_t  cmd,
    output nsct_pkg::dp_stat_t       stat,
    output logic                     rsp_valid,
    input  wire logic                rsp_ready,
    output nsct_pkg::rsp_t           rsp
);

    import nsct_pkg::*;

    localparam int LVL_W = (MAX_DEPTH > 2) ? $clog2(MAX_DEPTH) : 1;
    localparam logic [LVL_W-1:0] LEVEL_LAST = LVL_W'(MAX_DEPTH - 1);

    req_t              req_reg;
    logic [LVL_W-1:0]  level_reg, level_next;
    logic [31:0]       top_reg, top_next;
    logic [1:0]        status_reg;
    logic [2:0]        hcmd_reg;
    logic [31:0]       rd_data_reg;
    logic [31:0]       stack_reg [MAX_DEPTH];
    rsp_t              rsp_reg;
    logic              rsp_valid_reg, rsp_valid_next;
    logic [1:0]        status_c;
    logic [2:0]        hcmd_c;
    logic              push_c;

    // Capture the request word on acceptance.
    always_ff @(posedge clk)
    begin
        if (cmd.load_in)
        begin
            req_reg <= req;
        end
    end

    // Check the held command against the current level and top count.
    always_comb
    begin
        status_c = ST_OK;
        hcmd_c   = HC_NONE;
        case (req_reg.operation)
            OP_COMPLEX:
            begin
                if (top_reg == 32'd0)
                    status_c = ST_STATE;
                else if (level_reg == LEVEL_LAST)
                    status_c = ST_DATA;
                else if (req_reg.script_type == TYPE_ALL)
                    hcmd_c = HC_ALL;
                else if (req_reg.script_type == TYPE_ANY)
                    hcmd_c = HC_ANY;
                else if (req_reg.script_type == TYPE_NOFK)
                begin
                    if (req_reg.required_count <= req_reg.nested_count)
                        hcmd_c = HC_NOFK;
                    else
                        status_c = ST_DATA;
                end
                else
                    status_c = ST_DATA;
            end
            OP_SIMPLE:
            begin
                if (top_reg == 32'd0)
                    status_c = ST_STATE;
                else if (req_reg.script_type == TYPE_PUBKEY)
                begin
                    if (req_reg.key_reference == KEYREF_PATH ||
                        req_reg.key_reference == KEYREF_HASH)
                        hcmd_c = HC_PUBKEY;
                    else
                        status_c = ST_DATA;
                end
                else if (req_reg.script_type == TYPE_BEFORE)
                    hcmd_c = HC_BEFORE;
                else if (req_reg.script_type == TYPE_HEREAFTER)
                    hcmd_c = HC_HEREAFTER;
                else
                    status_c = ST_DATA;
            end
            OP_FINISH:
            begin
                if (level_reg != '0 || top_reg != 32'd0)
                    status_c = ST_STATE;
                else if (req_reg.finish_format == FMT_BECH32 ||
                         req_reg.finish_format == FMT_POLICY_ID)
                    hcmd_c = HC_FINALIZE;
                else
                    status_c = ST_DATA;
            end
            default:
            begin
                status_c = ST_REQUEST;
            end
        endcase
    end

    assign push_c = cmd.exec && (status_c == ST_OK) && (req_reg.operation == OP_COMPLEX);

    // Next level and top count: new call, push, use of one child, or a pop.
    always_comb
    begin
        level_next = level_reg;
        top_next   = top_reg;
        if (cmd.load_in && req.new_call)
        begin
            level_next = '0;
            top_next   = 32'd1;
        end
        else if (cmd.exec && status_c == ST_OK)
        begin
            if (req_reg.operation == OP_COMPLEX)
            begin
                level_next = level_reg + LVL_W'(1);
                top_next   = req_reg.nested_count;
            end
            else if (req_reg.operation == OP_SIMPLE)
            begin
                top_next = top_reg - 32'd1;
            end
        end
        else if (cmd.pop_ld)
        begin
            level_next = level_reg - LVL_W'(1);
            top_next   = rd_data_reg - {31'd0, (rd_data_reg != 32'd0)};
        end
    end

    // Level and top count registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            level_reg <= '0;
            top_reg   <= 32'd1;
        end
        else
        begin
            level_reg <= level_next;
            top_reg   <= top_next;
        end
    end

    // Result of the check, held until the response word is built.
    always_ff @(posedge clk)
    begin
        if (cmd.exec)
        begin
            status_reg <= status_c;
            hcmd_reg   <= hcmd_c;
        end
    end

    // Stack of parent counts: the top is saved on a push and read back on a pop.
    always_ff @(posedge clk)
    begin
        if (push_c)
        begin
            stack_reg[level_reg] <= top_reg;
        end
        if (cmd.pop_rd)
        begin
            rd_data_reg <= stack_reg[level_reg - LVL_W'(1)];
        end
    end

    // Response register with its valid flag.
    always_comb
    begin
        if (cmd.load_out)
            rsp_valid_next = 1'b1;
        else if (rsp_ready)
            rsp_valid_next = 1'b0;
        else
            rsp_valid_next = rsp_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_out)
        begin
            rsp_reg.status         <= status_reg;
            rsp_reg.hash_command   <= hcmd_reg;
            rsp_reg.depth          <= 3'(level_reg);
            rsp_reg.remaining_here <= top_reg;
        end
    end

    // Status to the controller.
    assign stat.pop_needed = (level_reg != '0) && (top_reg == 32'd0);
    assign stat.out_free   = !rsp_valid_reg || rsp_ready;

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

endmodule

`default_nettype wire

[hdl/nsct_controller.sv]
// Controller of the nested script count tracker: sequences acceptance, the check,
// the cascade of level pops and the hand-over of the response word.
// Depends on nsct_pkg.
`timescale 1ns / 1ps
`default_nettype none

module nsct_controller (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                req_valid,
    output logic                     req_ready,
    input  wire nsct_pkg::dp_stat_t  stat,
    output nsct_pkg::ctl_cmd_t       cmd
);

    import nsct_pkg::*;

    ctl_state_t state_reg, state_next;

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                    state_next = S_EXEC;
            end
            S_EXEC:
            begin
                state_next = S_POP_CHECK;
            end
            S_POP_CHECK:
            begin
                if (stat.pop_needed)
                    state_next = S_POP_LOAD;
                else
                    state_next = S_DONE;
            end
            S_POP_LOAD:
            begin
                state_next = S_POP_CHECK;
            end
            S_DONE:
            begin
                if (stat.out_free)
                    state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Commands to the datapath.
    always_comb
    begin
        cmd       = '0;
        req_ready = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                req_ready   = 1'b1;
                cmd.load_in = req_valid;
            end
            S_EXEC:
            begin
                cmd.exec = 1'b1;
            end
            S_POP_CHECK:
            begin
                cmd.pop_rd = stat.pop_needed;
            end
            S_POP_LOAD:
            begin
                cmd.pop_ld = 1'b1;
            end
            S_DONE:
            begin
                cmd.load_out = stat.out_free;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

    // State register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

`default_nettype wire

[hdl/nested_script_count_tracker_core.sv]
// Top level of the nested script count tracker: joins the controller and the datapath.
// Depends on nsct_pkg, nsct_controller and nsct_datapath.
//
//   Channel   Handshake               Word
//   request   req_valid / req_ready   req (nsct_pkg::req_t)
//   response  rsp_valid / rsp_ready   rsp (nsct_pkg::rsp_t)
//
// One word is handled at a time: after acceptance the controller passes S_EXEC and
// S_POP_CHECK, then S_POP_LOAD and S_POP_CHECK once per finished level popped (0 to
// MAX_DEPTH - 1), then S_DONE before the next acceptance. A pop needs S_POP_LOAD as
// the parent count comes from the stack memory through its registered read port.
// The response register frees the request side: a new word is accepted while the
// last response waits, and a further response only stalls the controller in S_DONE.
// After reset the depth is 0 and the root level expects one script.
`timescale 1ns / 1ps
`default_nettype none

module nested_script_count_tracker_core #(
    parameter int MAX_DEPTH = 8
) (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            req_valid,
    output logic                 req_ready,
    input  wire nsct_pkg::req_t  req,
    output logic                 rsp_valid,
    input  wire logic            rsp_ready,
    output nsct_pkg::rsp_t       rsp
);

    import nsct_pkg::*;

    ctl_cmd_t ctl_cmd;
    dp_stat_t dp_stat;

    // Command sequencing.
    nsct_controller u_controller (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .stat      (dp_stat),
        .cmd       (ctl_cmd)
    );

    // Checks, stack and response register.
    nsct_datapath #(
        .MAX_DEPTH (MAX_DEPTH)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req),
        .cmd       (ctl_cmd),
        .stat      (dp_stat),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp)
    );

endmodule

`default_nettype wire
